### src/nfd_pkg.sv
// Shared types and codes for the nonuniform first-derivative pipeline.
// No dependencies.
`default_nettype none

package nfd_pkg;

  // order select carried on tuser
  localparam logic [1:0] CMD_THREE = 2'd0;
  localparam logic [1:0] CMD_FOUR  = 2'd1;
  localparam logic [1:0] CMD_FIVE  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;  // behaves as five points

  // result status carried on tuser
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_BAD = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  localparam int NUM_NEIGHBORS = 4;
  localparam int NUM_PAIRS     = 6;
  localparam int NUM_LANES     = 5;  // four numerator terms and the denominator
  localparam int NUM_STEPS     = 5;  // narrow factors per lane
  localparam int DEN_LANE      = 4;

  // neighbor pairs (a,b), a < b, in the order 01 02 03 12 13 23
  localparam int PAIR_A [NUM_PAIRS] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_B [NUM_PAIRS] = '{1, 2, 3, 2, 3, 3};

  typedef struct packed {
    logic                 bad;   // zero or repeated offset
    logic                 nodd;  // stencil size minus one is even
    logic                 neg;   // result is negative
    logic                 high;  // quotient overflows the value width
    logic [NUM_LANES-1:0] sgn;   // sign of each lane product
  } ctl_t;

endpackage

`default_nettype wire

### src/nonuniform_first_derivative.sv
// Top level of the nonuniform first-derivative pipeline: exact rational evaluation,
// rounding divider and output skid. Depends on nfd_pkg.
`default_nettype none

// First derivative at a base point from a 3, 4 or 5 point nonuniform stencil with exact
// Lagrange weights. One word enters and one result leaves per clock unless m_tready holds
// the output and the skid register fills. The weights are brought over the common
// denominator D = prod(x) * prod(x_a - x_b), so the numerator is a sum of four terms, each
// the sample difference times five narrow factors. Every lane walks through five two-stage
// multiply steps (32-bit chunk partial products, then their sum), the terms are added, and
// a restoring divider retires one quotient bit per stage, VALUE_WIDTH stages, with the
// half-away-from-zero rounding folded into the dividend. An output register plus a skid
// register decouple m_tready from the pipeline; s_tready is registered.
module nonuniform_first_derivative
  import nfd_pkg::*;
#(
  parameter int OFFSET_WIDTH     = 16,
  parameter int OFFSET_FRAC_BITS = 8,
  parameter int VALUE_WIDTH      = 32
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  // offset_one, offset_two, offset_three, offset_four, value_zero .. value_four, zero fill
  input  wire  [((4*OFFSET_WIDTH+5*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
  // cmd
  input  wire  [1:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  // derivative, zero fill
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]      m_tdata,
  // status
  output logic [1:0]                            m_tuser
);

  localparam int OW    = OFFSET_WIDTH;
  localparam int VW    = VALUE_WIDTH;
  localparam int EW    = OW + 1;            // offset difference
  localparam int DVW   = VW + 1;            // sample difference
  localparam int FSW   = 2 * OW + 1;        // signed narrow factor
  localparam int FMW   = 2 * OW;            // factor magnitude
  localparam int CW    = 32;                // multiplier chunk
  localparam int LWR   = VW + NUM_STEPS * FMW;
  localparam int NCH   = (LWR + CW - 1) / CW;
  localparam int LW    = NCH * CW;          // lane magnitude
  localparam int PW    = CW + FMW;          // partial product
  localparam int NW    = LW + 3;            // signed numerator
  localparam int AW    = NW + OFFSET_FRAC_BITS + VW + 2;  // divider
  localparam int MS    = 2 * NUM_STEPS;
  localparam int NSV   = 9 + MS + VW;       // pipeline stages ahead of the output
  localparam int ODW   = ((VW + 7) / 8) * 8;

  // ---------------------------------------------------------------- input fields
  logic signed [OW-1:0] xin [NUM_NEIGHBORS];
  logic signed [VW-1:0] vin [NUM_NEIGHBORS+1];
  logic [NUM_NEIGHBORS-1:0] act;
  logic                 bad_in;

  always_comb begin
    for (int k = 0; k < NUM_NEIGHBORS; k++) xin[k] = s_tdata[k*OW +: OW];
    for (int k = 0; k <= NUM_NEIGHBORS; k++) vin[k] = s_tdata[4*OW + k*VW +: VW];
  end

  // neighbors in use form a prefix; code three acts as five points
  assign act = {s_tuser[1], s_tuser != CMD_THREE, 2'b11};

  always_comb begin
    bad_in = 1'b0;
    for (int k = 0; k < NUM_NEIGHBORS; k++)
      if (act[k] && xin[k] == '0) bad_in = 1'b1;
    for (int p = 0; p < NUM_PAIRS; p++)
      if (act[PAIR_A[p]] && act[PAIR_B[p]] && xin[PAIR_A[p]] == xin[PAIR_B[p]])
        bad_in = 1'b1;
  end

  // ---------------------------------------------------------------- flow control
  logic           en;
  logic           skid_v;
  logic [NSV-1:0] vld;

  assign en       = !skid_v;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSV-2:0], s_tvalid};
    end
  end

  // ---------------------------------------------------------------- stage registers
  logic signed [OW-1:0]  x1 [NUM_NEIGHBORS];
  logic signed [EW-1:0]  e1 [NUM_PAIRS];
  logic signed [DVW-1:0] d1 [NUM_NEIGHBORS];
  ctl_t                  ctl1;

  logic signed [FSW-1:0] f2 [NUM_LANES][NUM_STEPS];
  logic [VW-1:0]         dm2 [NUM_NEIGHBORS];
  ctl_t                  ctl2;

  logic [FMW-1:0] fmq  [0:MS][NUM_LANES][NUM_STEPS];
  ctl_t           ctlm [0:MS];
  logic [LW-1:0]  accq [0:NUM_STEPS][NUM_LANES];
  logic [PW-1:0]  pp   [NUM_STEPS][NUM_LANES][NCH];
  logic [LW-1:0]  sumv [NUM_STEPS][NUM_LANES];

  logic [NW-1:0]  tn [NUM_NEIGHBORS];
  logic [LW-1:0]  dmt, dmq, dmn, dmb;
  ctl_t           ctlt, ctlq, ctln, ctlb, ctlp;
  logic [NW-1:0]  qs0, qs1, nn, nabs;
  logic [AW-1:0]  pa, pb;

  logic [AW-1:0]  remd [0:VW];
  logic [AW-1:0]  bd   [0:VW];
  logic [VW-1:0]  qd   [0:VW];
  ctl_t           ctld [0:VW];

  // ---------------------------------------------------------------- factor products
  function automatic logic signed [FSW-1:0] fxx(input logic signed [OW-1:0] a,
                                                input logic signed [OW-1:0] b);
    logic signed [2*OW-1:0] p;
    p = a * b;
    return FSW'(p);
  endfunction

  function automatic logic signed [FSW-1:0] fee(input logic signed [EW-1:0] a,
                                                input logic signed [EW-1:0] b);
    logic signed [2*EW-1:0] p;
    p = a * b;
    return p[FSW-1:0];
  endfunction

  function automatic logic signed [FSW-1:0] fe(input logic signed [EW-1:0] a);
    return FSW'(a);
  endfunction

  function automatic logic [FMW-1:0] fmag(input logic signed [FSW-1:0] a);
    logic signed [FSW-1:0] m;
    m = a[FSW-1] ? -a : a;
    return m[FMW-1:0];
  endfunction

  // lane i collects (product of the other offsets)^2 and the pairs that avoid i;
  // the denominator lane collects all offsets and all pairs
  logic signed [FSW-1:0] f2_next [NUM_LANES][NUM_STEPS];
  always_comb begin
    f2_next[0] = '{fxx(x1[1], x1[2]), fxx(x1[1], x1[3]), fxx(x1[2], x1[3]),
                   fee(e1[3], e1[4]), fe(e1[5])};
    f2_next[1] = '{fxx(x1[0], x1[2]), fxx(x1[0], x1[3]), fxx(x1[2], x1[3]),
                   fee(e1[1], e1[2]), fe(e1[5])};
    f2_next[2] = '{fxx(x1[0], x1[1]), fxx(x1[0], x1[3]), fxx(x1[1], x1[3]),
                   fee(e1[0], e1[2]), fe(e1[4])};
    f2_next[3] = '{fxx(x1[0], x1[1]), fxx(x1[0], x1[2]), fxx(x1[1], x1[2]),
                   fee(e1[0], e1[1]), fe(e1[3])};
    f2_next[4] = '{fxx(x1[0], x1[1]), fxx(x1[2], x1[3]), fee(e1[0], e1[1]),
                   fee(e1[2], e1[3]), fee(e1[4], e1[5])};
  end

  // sample difference signs, then full lane signs
  logic [NUM_LANES-1:0] dsgn;
  logic [NUM_LANES-1:0] lsgn;

  always_comb begin
    dsgn = '0;
    for (int k = 0; k < NUM_NEIGHBORS; k++) dsgn[k] = d1[k][DVW-1];
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lsgn[l] = ctl2.sgn[l];
      for (int s = 0; s < NUM_STEPS; s++) lsgn[l] = lsgn[l] ^ f2[l][s][FSW-1];
      if (l != DEN_LANE) lsgn[l] = lsgn[l] ^ ctl2.nodd ^ (l % 2 == 1);
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_STEPS; s++)
      for (int l = 0; l < NUM_LANES; l++) begin
        sumv[s][l] = '0;
        for (int c = 0; c < NCH; c++)
          sumv[s][l] = sumv[s][l] + (LW'(pp[s][l][c]) << (c * CW));
      end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: masking, differences, offset checks
      for (int k = 0; k < NUM_NEIGHBORS; k++) begin
        x1[k] <= act[k] ? xin[k] : OW'(1);
        d1[k] <= act[k] ? DVW'(vin[k+1]) - DVW'(vin[0]) : '0;
      end
      for (int p = 0; p < NUM_PAIRS; p++)
        e1[p] <= (act[PAIR_A[p]] && act[PAIR_B[p]]) ?
                 EW'(xin[PAIR_A[p]]) - EW'(xin[PAIR_B[p]]) : EW'(1);
      ctl1 <= '{bad: bad_in, nodd: (s_tuser != CMD_FOUR), neg: 1'b0, high: 1'b0,
                sgn: '0};

      // stage 2: narrow factors, sample difference magnitudes
      f2   <= f2_next;
      ctl2 <= '{bad: ctl1.bad, nodd: ctl1.nodd, neg: ctl1.neg, high: ctl1.high,
                sgn: dsgn};
      for (int k = 0; k < NUM_NEIGHBORS; k++)
        dm2[k] <= d1[k][DVW-1] ? VW'(-d1[k]) : VW'(d1[k]);

      // stage 3: factor magnitudes, lane signs
      ctlm[0] <= '{bad: ctl2.bad, nodd: ctl2.nodd, neg: ctl2.neg, high: ctl2.high,
                   sgn: lsgn};
      for (int l = 0; l < NUM_LANES; l++)
        for (int s = 0; s < NUM_STEPS; s++)
          fmq[0][l][s] <= fmag(f2[l][s]);
      for (int l = 0; l < NUM_NEIGHBORS; l++)
        accq[0][l] <= LW'(dm2[l]);
      accq[0][DEN_LANE] <= LW'(1);

      // multiply steps: chunk partial products, then their sum
      for (int s = 0; s < NUM_STEPS; s++) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          for (int c = 0; c < NCH; c++)
            pp[s][l][c] <= PW'(accq[s][l][c*CW +: CW]) * PW'(fmq[2*s][l][s]);
          accq[s+1][l] <= sumv[s][l];
        end
        fmq[2*s+1]  <= fmq[2*s];
        fmq[2*s+2]  <= fmq[2*s+1];
        ctlm[2*s+1] <= ctlm[2*s];
        ctlm[2*s+2] <= ctlm[2*s+1];
      end

      // signed terms
      for (int l = 0; l < NUM_NEIGHBORS; l++)
        tn[l] <= ctlm[MS].sgn[l] ? -NW'(accq[NUM_STEPS][l]) : NW'(accq[NUM_STEPS][l]);
      dmt  <= accq[NUM_STEPS][DEN_LANE];
      ctlt <= ctlm[MS];

      // term sum in two levels
      qs0  <= tn[0] + tn[1];
      qs1  <= tn[2] + tn[3];
      dmq  <= dmt;
      ctlq <= ctlt;
      nn   <= qs0 + qs1;
      dmn  <= dmq;
      ctln <= ctlq;

      // magnitude and result sign
      nabs <= nn[NW-1] ? -nn : nn;
      dmb  <= dmn;
      ctlb <= '{bad: ctln.bad, nodd: ctln.nodd, neg: nn[NW-1] ^ ctln.sgn[DEN_LANE],
                high: ctln.high, sgn: ctln.sgn};

      // rounding: floor((2|N|*2^F + D) / 2D)
      pa   <= (AW'(nabs) << (OFFSET_FRAC_BITS + 1)) + AW'(dmb);
      pb   <= AW'(dmb) << 1;
      ctlp <= ctlb;

      // overflow check, divider seed
      remd[0] <= pa;
      bd[0]   <= pb;
      qd[0]   <= '0;
      ctld[0] <= '{bad: ctlp.bad, nodd: ctlp.nodd, neg: ctlp.neg,
                   high: pa >= (pb << VW), sgn: ctlp.sgn};

      // restoring divider, one quotient bit per stage, MSB first
      for (int j = 0; j < VW; j++) begin
        if (remd[j] >= (bd[j] << (VW - 1 - j))) begin
          remd[j+1] <= remd[j] - (bd[j] << (VW - 1 - j));
          qd[j+1]   <= qd[j] | (VW'(1) << (VW - 1 - j));
        end else begin
          remd[j+1] <= remd[j];
          qd[j+1]   <= qd[j];
        end
        bd[j+1]   <= bd[j];
        ctld[j+1] <= ctld[j];
      end
    end
  end

  // ---------------------------------------------------------------- saturation
  logic [VW-1:0] res_d;
  logic [1:0]    res_s;
  logic [VW-1:0] qv;
  ctl_t          cv;

  assign qv = qd[VW];
  assign cv = ctld[VW];

  always_comb begin
    if (cv.bad) begin
      res_d = '0;
      res_s = STATUS_BAD;
    end else if (!cv.neg && (cv.high || qv[VW-1])) begin
      res_d = {1'b0, {(VW-1){1'b1}}};
      res_s = STATUS_SAT;
    end else if (cv.neg && (cv.high || (qv[VW-1] && (|qv[VW-2:0])))) begin
      res_d = {1'b1, {(VW-1){1'b0}}};
      res_s = STATUS_SAT;
    end else begin
      res_d = cv.neg ? -qv : qv;
      res_s = STATUS_OK;
    end
  end

  // ---------------------------------------------------------------- output + skid
  logic [VW-1:0] skid_d;
  logic [1:0]    skid_s;
  logic [VW-1:0] out_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (skid_v) begin
      if (m_tready) begin
        out_d   <= skid_d;
        m_tuser <= skid_s;
        skid_v  <= 1'b0;
      end
    end else if (vld[NSV-1]) begin
      if (!m_tvalid || m_tready) begin
        out_d    <= res_d;
        m_tuser  <= res_s;
        m_tvalid <= 1'b1;
      end else begin
        skid_d <= res_d;
        skid_s <= res_s;
        skid_v <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = ODW'(out_d);

endmodule

`default_nettype wire
